// ===== design/swerve_wheel_kinematics_assert.svh =====
// Assertion helpers for the swerve kinematics block
`ifndef SWERVE_WHEEL_KINEMATICS_ASSERT_SVH
`define SWERVE_WHEEL_KINEMATICS_ASSERT_SVH

// Check that a condition is followed by another one after the delay given by n
`define SWK_ASSERT_DELAY(lbl, clk, rst, a, n, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> ##n (b)) \
    else $error("delayed check failed");

// Check that a condition implies another one in the same cycle
`define SWK_ASSERT_IMPLY(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");

`endif

// ===== design/swk_pkg.sv =====
package swk_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int WHEELS = 4;
  localparam int VEC_W = 33;
  localparam int CW = 36;
  localparam int ACC_W = 32;
  localparam int MAG_W = 34;
  localparam int MAG_LO_W = 17;
  localparam int GAIN_W = 30;
  localparam int PROD_W = 64;
  localparam int HFULL_W = 39;
  localparam int SPEED_W = 17;
  localparam int ANGLE_W = 16;
  localparam int ERPM_W = 16;
  localparam int LATENCY = CORDIC_STAGES + 6;

  localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;
  localparam logic signed [16:0] K45 = 17'sd23170;
  localparam logic signed [16:0] K30 = 17'sd28378;
  localparam logic signed [16:0] KHALF = 17'sd16384;
  localparam logic signed [16:0] KONE = 17'sd32768;
  localparam logic signed [VEC_W-1:0] NEAR_ZERO = 33'sd402653;
  localparam logic signed [ACC_W-1:0] ANG_180 = 32'sd188743680;
  localparam logic signed [ACC_W-1:0] ANG_360 = 32'sd377487360;
  localparam logic [HFULL_W-1:0] ANG_HALF = 39'd524288;
  localparam logic [18:0] HUND_360 = 19'd36000;
  localparam logic [ERPM_W-1:0] ERPM_RESET = 16'd1000;

  localparam logic [1:0] CFG_ERPM = 2'd0;
  localparam logic [1:0] CFG_MODE = 2'd1;

  localparam logic [1:0] OVR_NONE = 2'd0;
  localparam logic [1:0] OVR_ZERO = 2'd1;
  localparam logic [1:0] OVR_UP = 2'd2;
  localparam logic [1:0] OVR_DOWN = 2'd3;

  localparam logic [ANGLE_W-1:0] ANGLE_UP = 16'd9000;
  localparam logic [ANGLE_W-1:0] ANGLE_DOWN = 16'd27000;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_rot;
  } cmd_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_one;
    logic [ANGLE_W-1:0] angle_one;
    logic [SPEED_W-1:0] speed_two;
    logic [ANGLE_W-1:0] angle_two;
    logic [SPEED_W-1:0] speed_three;
    logic [ANGLE_W-1:0] angle_three;
    logic [SPEED_W-1:0] speed_four;
    logic [ANGLE_W-1:0] angle_four;
  } result_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
  } wvec_t;

  typedef struct packed {
    logic signed [16:0] tx;
    logic signed [16:0] ty;
  } tan_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ACC_W-1:0] acc;
    logic [1:0] ovr;
  } cordic_t;

  // atan(2^-i) in 2^-20 degree
  function automatic logic signed [ACC_W-1:0] atan_q20(input int i);
    logic signed [ACC_W-1:0] t;
    case (i)
      0: t = 32'sd47185920;
      1: t = 32'sd27855475;
      2: t = 32'sd14718068;
      3: t = 32'sd7471121;
      4: t = 32'sd3750058;
      5: t = 32'sd1876857;
      6: t = 32'sd938658;
      7: t = 32'sd469357;
      8: t = 32'sd234682;
      9: t = 32'sd117342;
      10: t = 32'sd58671;
      11: t = 32'sd29335;
      12: t = 32'sd14668;
      13: t = 32'sd7334;
      14: t = 32'sd3667;
      15: t = 32'sd1833;
      16: t = 32'sd917;
      17: t = 32'sd458;
      18: t = 32'sd229;
      19: t = 32'sd115;
      20: t = 32'sd57;
      21: t = 32'sd29;
      22: t = 32'sd14;
      23: t = 32'sd7;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Unit tangent of a wheel, Q2.15
  function automatic tan_t tangent(input logic four, input int k);
    tan_t t;
    t.tx = '0;
    t.ty = '0;
    if (four) begin
      case (k)
        0: begin t.tx = -K45; t.ty = K45; end
        1: begin t.tx = -K45; t.ty = -K45; end
        2: begin t.tx = K45; t.ty = -K45; end
        3: begin t.tx = K45; t.ty = K45; end
        default: t = '0;
      endcase
    end else begin
      case (k)
        0: begin t.tx = K30; t.ty = -KHALF; end
        1: begin t.tx = '0; t.ty = KONE; end
        2: begin t.tx = -K30; t.ty = -KHALF; end
        default: t = '0;
      endcase
    end
    return t;
  endfunction

endpackage

// ===== design/swk_vec.sv =====
module swk_vec (
  input  logic             clk,
  input  swk_pkg::cmd_t    cmd,
  input  logic             mode,
  output swk_pkg::wvec_t   vec [swk_pkg::WHEELS]
);

  // Add the rotation term along each wheel tangent
  for (genvar k = 0; k < swk_pkg::WHEELS; k++) begin : g_wheel
    swk_pkg::tan_t t;
    logic signed [swk_pkg::VEC_W-1:0] vx;
    logic signed [swk_pkg::VEC_W-1:0] vy;
    logic signed [swk_pkg::VEC_W-1:0] wx;
    logic signed [swk_pkg::VEC_W-1:0] wy;

    always_comb begin
      t = swk_pkg::tangent(mode, k);
      vx = swk_pkg::VEC_W'(cmd.vel_x) <<< 15;
      vy = swk_pkg::VEC_W'(cmd.vel_y) <<< 15;
      wx = cmd.vel_rot * t.tx;
      wy = cmd.vel_rot * t.ty;
    end

    always_ff @(posedge clk) begin
      vec[k].x <= vx + wx;
      vec[k].y <= vy + wy;
    end
  end

endmodule

// ===== design/swk_cordic.sv =====
module swk_cordic (
  input  logic              clk,
  input  swk_pkg::wvec_t    vec,
  output swk_pkg::cordic_t  res
);

  swk_pkg::cordic_t st [swk_pkg::CORDIC_STAGES+1];
  logic near_x;

  assign near_x = (vec.x <= swk_pkg::NEAR_ZERO) && (vec.x >= -swk_pkg::NEAR_ZERO);

  // Fold into the right half plane and flag near-vertical vectors
  always_ff @(posedge clk) begin
    if (vec.x < 0) begin
      st[0].x <= -swk_pkg::CW'(vec.x);
      st[0].y <= -swk_pkg::CW'(vec.y);
      st[0].acc <= swk_pkg::ANG_180;
    end else begin
      st[0].x <= swk_pkg::CW'(vec.x);
      st[0].y <= swk_pkg::CW'(vec.y);
      st[0].acc <= '0;
    end
    if (!near_x) begin
      st[0].ovr <= swk_pkg::OVR_NONE;
    end else if (vec.y < -swk_pkg::NEAR_ZERO) begin
      st[0].ovr <= swk_pkg::OVR_DOWN;
    end else if (vec.y > swk_pkg::NEAR_ZERO) begin
      st[0].ovr <= swk_pkg::OVR_UP;
    end else begin
      st[0].ovr <= swk_pkg::OVR_ZERO;
    end
  end

  // One vectoring rotation per stage
  for (genvar i = 0; i < swk_pkg::CORDIC_STAGES; i++) begin : g_iter
    logic signed [swk_pkg::CW-1:0] dx;
    logic signed [swk_pkg::CW-1:0] dy;

    assign dx = $signed(st[i].y) >>> i;
    assign dy = $signed(st[i].x) >>> i;

    always_ff @(posedge clk) begin
      st[i+1].ovr <= st[i].ovr;
      if (!st[i].y[swk_pkg::CW-1]) begin
        st[i+1].x <= st[i].x + dx;
        st[i+1].y <= st[i].y - dy;
        st[i+1].acc <= st[i].acc + swk_pkg::atan_q20(i);
      end else begin
        st[i+1].x <= st[i].x - dx;
        st[i+1].y <= st[i].y + dy;
        st[i+1].acc <= st[i].acc - swk_pkg::atan_q20(i);
      end
    end
  end

  assign res = st[swk_pkg::CORDIC_STAGES];

endmodule

// ===== design/swk_post.sv =====
module swk_post (
  input  logic                          clk,
  input  swk_pkg::cordic_t              c,
  input  logic [swk_pkg::ERPM_W-1:0]    erpm,
  output logic [swk_pkg::SPEED_W-1:0]   speed,
  output logic [swk_pkg::ANGLE_W-1:0]   angle
);

  localparam int PP_W = swk_pkg::MAG_LO_W + swk_pkg::GAIN_W;
  localparam int SP_W = swk_pkg::MAG_W + swk_pkg::ERPM_W;

  logic [PP_W-1:0] p_hi;
  logic [PP_W-1:0] p_lo;
  logic [swk_pkg::HFULL_W-1:0] hfull;
  logic [1:0] ovr1;
  logic [swk_pkg::MAG_W-1:0] mag;
  logic [swk_pkg::ANGLE_W-1:0] ang2;
  logic [SP_W-1:0] prod;
  logic [swk_pkg::ANGLE_W-1:0] ang3;

  logic [swk_pkg::ACC_W-1:0] apos;
  logic [swk_pkg::PROD_W-1:0] msum;
  logic [18:0] hund;
  logic [swk_pkg::ANGLE_W-1:0] hwrap;

  // Wrap the angle into 0..360 degrees
  assign apos = c.acc[swk_pkg::ACC_W-1] ? swk_pkg::ACC_W'(c.acc + swk_pkg::ANG_360)
                                        : swk_pkg::ACC_W'(c.acc);

  // Split the gain product in two halves, scale the angle to hundredths
  always_ff @(posedge clk) begin
    p_hi <= PP_W'(c.x[swk_pkg::MAG_W-1:swk_pkg::MAG_LO_W]) * PP_W'(swk_pkg::INV_GAIN);
    p_lo <= PP_W'(c.x[swk_pkg::MAG_LO_W-1:0]) * PP_W'(swk_pkg::INV_GAIN);
    hfull <= swk_pkg::HFULL_W'(apos) * swk_pkg::HFULL_W'(100) + swk_pkg::ANG_HALF;
    ovr1 <= c.ovr;
  end

  assign msum = (swk_pkg::PROD_W'(p_hi) << swk_pkg::MAG_LO_W) + swk_pkg::PROD_W'(p_lo);
  assign hund = hfull[swk_pkg::HFULL_W-1:20];
  assign hwrap = (hund >= swk_pkg::HUND_360) ? swk_pkg::ANGLE_W'(hund - swk_pkg::HUND_360)
                                             : swk_pkg::ANGLE_W'(hund);

  // Combine halves, pick the final angle
  always_ff @(posedge clk) begin
    mag <= msum[swk_pkg::PROD_W-1:swk_pkg::PROD_W-swk_pkg::MAG_W];
    case (ovr1)
      swk_pkg::OVR_NONE: ang2 <= hwrap;
      swk_pkg::OVR_UP: ang2 <= swk_pkg::ANGLE_UP;
      swk_pkg::OVR_DOWN: ang2 <= swk_pkg::ANGLE_DOWN;
      default: ang2 <= '0;
    endcase
  end

  // Scale to ERPM
  always_ff @(posedge clk) begin
    prod <= SP_W'(mag) * SP_W'(erpm);
    ang3 <= ang2;
  end

  // Saturate the speed
  assign speed = (|prod[SP_W-1:27+swk_pkg::SPEED_W]) ? '1 : prod[26+swk_pkg::SPEED_W:27];
  assign angle = ang3;

endmodule

// ===== design/swerve_wheel_kinematics.sv =====
// Each item accepted on an edge of start is answered by one done strobe.
// Throughput: one item per cycle outside reset; start may be high in every cycle.
// Depth is set by the 16 stages of CORDIC rotation plus six datapath stages.
// The receiver cannot stall, so busy is only high while rst is held.
// Synchronous reset clears the valid line and loads erpm_per_mps 1000 and
// wheel_count_mode 1 (four wheels).
`include "swerve_wheel_kinematics_assert.svh"

module swerve_wheel_kinematics (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  swk_pkg::cmd_t                  cmd,
  output logic                           done,
  output swk_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [15:0]                    cfg_data
);

  logic [swk_pkg::ERPM_W-1:0] erpm_per_mps;
  logic wheel_count_mode;
  logic [swk_pkg::LATENCY-1:0] vld;
  logic [swk_pkg::LATENCY-1:0] mode_d;
  logic accept;

  swk_pkg::wvec_t vec [swk_pkg::WHEELS];
  swk_pkg::cordic_t cres [swk_pkg::WHEELS];
  logic [swk_pkg::SPEED_W-1:0] spd [swk_pkg::WHEELS];
  logic [swk_pkg::ANGLE_W-1:0] ang [swk_pkg::WHEELS];

  assign busy = rst;
  assign cfg_ready = 1'b1;
  assign accept = start && !busy;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      erpm_per_mps <= swk_pkg::ERPM_RESET;
      wheel_count_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        swk_pkg::CFG_ERPM: erpm_per_mps <= cfg_data;
        swk_pkg::CFG_MODE: wheel_count_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance valid and layout bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[swk_pkg::LATENCY-2:0], accept};
    end
    mode_d <= {mode_d[swk_pkg::LATENCY-2:0], wheel_count_mode};
  end

  swk_vec u_vec (
    .clk  (clk),
    .cmd  (cmd),
    .mode (wheel_count_mode),
    .vec  (vec)
  );

  for (genvar k = 0; k < swk_pkg::WHEELS; k++) begin : g_wheel
    swk_cordic u_cordic (
      .clk (clk),
      .vec (vec[k]),
      .res (cres[k])
    );
    swk_post u_post (
      .clk   (clk),
      .c     (cres[k]),
      .erpm  (erpm_per_mps),
      .speed (spd[k]),
      .angle (ang[k])
    );
  end

  // Register the result; drop wheel four in the three-wheel layout
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[swk_pkg::LATENCY-2];
    end
    result.speed_one <= spd[0];
    result.angle_one <= ang[0];
    result.speed_two <= spd[1];
    result.angle_two <= ang[1];
    result.speed_three <= spd[2];
    result.angle_three <= ang[2];
    result.speed_four <= mode_d[swk_pkg::LATENCY-2] ? spd[3] : '0;
    result.angle_four <= mode_d[swk_pkg::LATENCY-2] ? ang[3] : '0;
  end

  `SWK_ASSERT_DELAY(a_latency, clk, rst, accept, (swk_pkg::LATENCY), done)
  `SWK_ASSERT_IMPLY(a_three_zero, clk, rst, done && !mode_d[swk_pkg::LATENCY-1], result.speed_four == '0 && result.angle_four == '0)
  `SWK_ASSERT_IMPLY(a_angle_range, clk, rst, done, result.angle_one < 16'd36000 && result.angle_two < 16'd36000 && result.angle_three < 16'd36000)

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF = 4;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int NUM_DIRECTED = 20;
  localparam int DRAIN_CYCLES = swk_pkg::LATENCY + 8;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  swk_pkg::cmd_t cmd;
  logic done;
  swk_pkg::result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  // predictor copy of the registers
  logic [15:0] erpm_scale;
  logic four_wheel;

  swk_pkg::result_t wheel_q[$];
  int cycle_count = 0;
  bit failed = 1'b0;

  // directed rows: command, and a typed-in result where the answer is obvious
  typedef struct {
    swk_pkg::cmd_t c;
    bit has_fixed;
    swk_pkg::result_t r;
  } row_t;
  row_t rows[NUM_DIRECTED];

  swerve_wheel_kinematics u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // polar form of one wheel vector, in units of 2^-27 m/s
  function automatic void wheel_to_polar(input longint x, input longint y,
                                         output logic [16:0] spd,
                                         output logic [15:0] ang);
    longint cx, cy, acc, dx, dy, h;
    longint unsigned mag, s;
    longint atan_tab[24];
    atan_tab = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
                 938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334,
                 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
    cx = x;
    cy = y;
    acc = 0;
    if (cx < 0) begin
      cx = -cx;
      cy = -cy;
      acc = 64'sd180 <<< 20;
    end
    for (int i = 0; i < swk_pkg::CORDIC_STAGES && i < 24; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx;
        cy -= dy;
        acc += atan_tab[i];
      end else begin
        cx -= dx;
        cy += dy;
        acc -= atan_tab[i];
      end
    end
    mag = (longint'(cx) * 64'd652032874) >> 30;
    s = (mag * erpm_scale) >> 27;
    spd = (s > 131071) ? 17'd131071 : s[16:0];
    if (x <= 402653 && x >= -402653) begin
      if (y < -402653) ang = swk_pkg::ANGLE_DOWN;
      else if (y > 402653) ang = swk_pkg::ANGLE_UP;
      else ang = '0;
    end else begin
      if (acc < 0) acc += 64'sd360 <<< 20;
      h = (acc * 100 + (64'sd1 <<< 19)) >>> 20;
      if (h >= 36000) h -= 36000;
      ang = h[15:0];
    end
  endfunction

  function automatic swk_pkg::result_t wheel_commands(input swk_pkg::cmd_t c);
    swk_pkg::result_t r;
    longint vx, vy, w;
    swk_pkg::tan_t t;
    logic [16:0] s[4];
    logic [15:0] a[4];
    vx = longint'(c.vel_x) * 32768;
    vy = longint'(c.vel_y) * 32768;
    w = longint'(c.vel_rot);
    for (int k = 0; k < 4; k++) begin
      s[k] = '0;
      a[k] = '0;
      if (four_wheel || k < 3) begin
        t = swk_pkg::tangent(four_wheel, k);
        wheel_to_polar(vx + w * longint'(t.tx), vy + w * longint'(t.ty), s[k], a[k]);
      end
    end
    r.speed_one = s[0]; r.angle_one = a[0];
    r.speed_two = s[1]; r.angle_two = a[1];
    r.speed_three = s[2]; r.angle_three = a[2];
    r.speed_four = s[3]; r.angle_four = a[3];
    return r;
  endfunction

  // write one register, then leave the channel idle
  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == swk_pkg::CFG_ERPM) erpm_scale = val;
    else if (idx == swk_pkg::CFG_MODE) four_wheel = val[0];
    @(posedge clk);
  endtask

  // send one item; the expectation is queued on the accepting edge
  task automatic send_cmd(input swk_pkg::cmd_t c, input bit use_fixed,
                          input swk_pkg::result_t fixed, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    wheel_q.push_back(use_fixed ? fixed : wheel_commands(c));
  endtask

  task automatic drain();
    while (wheel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // compare each done strobe with the oldest expectation
  always @(posedge clk) begin
    swk_pkg::result_t e;
    if (!rst && done) begin
      if (wheel_q.size() == 0) begin
        $error("result with nothing expected");
        failed = 1'b1;
      end else begin
        e = wheel_q.pop_front();
        if (result.speed_one !== e.speed_one) begin
          $error("speed_one exp %0d got %0d", e.speed_one, result.speed_one); failed = 1'b1; end
        if (result.angle_one !== e.angle_one) begin
          $error("angle_one exp %0d got %0d", e.angle_one, result.angle_one); failed = 1'b1; end
        if (result.speed_two !== e.speed_two) begin
          $error("speed_two exp %0d got %0d", e.speed_two, result.speed_two); failed = 1'b1; end
        if (result.angle_two !== e.angle_two) begin
          $error("angle_two exp %0d got %0d", e.angle_two, result.angle_two); failed = 1'b1; end
        if (result.speed_three !== e.speed_three) begin
          $error("speed_three exp %0d got %0d", e.speed_three, result.speed_three);
          failed = 1'b1;
        end
        if (result.angle_three !== e.angle_three) begin
          $error("angle_three exp %0d got %0d", e.angle_three, result.angle_three);
          failed = 1'b1;
        end
        if (result.speed_four !== e.speed_four) begin
          $error("speed_four exp %0d got %0d", e.speed_four, result.speed_four);
          failed = 1'b1;
        end
        if (result.angle_four !== e.angle_four) begin
          $error("angle_four exp %0d got %0d", e.angle_four, result.angle_four);
          failed = 1'b1;
        end
      end
    end
  end

  // stop a hung run
  always @(posedge clk) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic swk_pkg::cmd_t mk(input int x, input int y, input int w);
    swk_pkg::cmd_t c;
    c.vel_x = x[15:0];
    c.vel_y = y[15:0];
    c.vel_rot = w[15:0];
    return c;
  endfunction

  function automatic swk_pkg::cmd_t rand_cmd();
    swk_pkg::cmd_t c;
    case ($urandom_range(0, 3))
      0: c = mk(int'($urandom_range(0, 40)) - 20, int'($urandom_range(0, 40)) - 20,
                int'($urandom_range(0, 40)) - 20);
      1: c = mk(int'($urandom_range(0, 8000)) - 4000, int'($urandom_range(0, 8000)) - 4000,
                int'($urandom_range(0, 8000)) - 4000);
      default: c = mk(int'($urandom), int'($urandom), int'($urandom));
    endcase
    return c;
  endfunction

  initial begin
    swk_pkg::result_t zero_r;
    logic [15:0] scales[6];
    zero_r = '0;
    scales = '{16'd1, 16'd65535, 16'd0, 16'd4096, 16'd1000, 16'd30000};
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    erpm_scale = swk_pkg::ERPM_RESET;
    four_wheel = 1'b1;

    // directed table: zero vector gives all zeros; the rest go to the predictor
    rows[0] = '{mk(0, 0, 0), 1'b1, zero_r};
    rows[1] = '{mk(32767, 0, 0), 1'b0, zero_r};
    rows[2] = '{mk(-32768, 0, 0), 1'b0, zero_r};
    rows[3] = '{mk(0, 32767, 0), 1'b0, zero_r};
    rows[4] = '{mk(0, -32768, 0), 1'b0, zero_r};
    rows[5] = '{mk(0, 0, 32767), 1'b0, zero_r};
    rows[6] = '{mk(0, 0, -32768), 1'b0, zero_r};
    rows[7] = '{mk(32767, 32767, 32767), 1'b0, zero_r};
    rows[8] = '{mk(-32768, -32768, -32768), 1'b0, zero_r};
    rows[9] = '{mk(12, 5000, 0), 1'b0, zero_r};
    rows[10] = '{mk(-12, -5000, 0), 1'b0, zero_r};
    rows[11] = '{mk(13, 5, 0), 1'b0, zero_r};
    rows[12] = '{mk(-13, -5, 0), 1'b0, zero_r};
    rows[13] = '{mk(5, 12, 0), 1'b0, zero_r};
    rows[14] = '{mk(-1, 1, 0), 1'b0, zero_r};
    rows[15] = '{mk(-4096, 1, 0), 1'b0, zero_r};
    rows[16] = '{mk(-4096, -1, 0), 1'b0, zero_r};
    rows[17] = '{mk(4096, 4096, 0), 1'b0, zero_r};
    rows[18] = '{mk(0, 0, 4096), 1'b0, zero_r};
    rows[19] = '{mk(-21845, 21845, 21845), 1'b0, zero_r};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pass at reset settings, then in three-wheel mode
    for (int p = 0; p < 2; p++) begin
      if (p == 1) cfg_write(swk_pkg::CFG_MODE, 16'hFFFE);
      for (int i = 0; i < NUM_DIRECTED; i++) begin
        send_cmd(rows[i].c, rows[i].has_fixed, rows[i].r, p == 1);
      end
      start <= 1'b0;
      drain();
    end

    // random phases over scale and layout settings
    for (int ph = 0; ph < 12; ph++) begin
      cfg_write(swk_pkg::CFG_ERPM, scales[ph % 6]);
      cfg_write(swk_pkg::CFG_MODE, 16'(ph / 6));
      if (ph == 5) cfg_write(CFG_UNUSED, 16'h1234);
      for (int n = 0; n < RANDOM_ITEMS / 12; n++) begin
        // back-to-back stretch every other phase
        send_cmd(rand_cmd(), 1'b0, zero_r, ph[0]);
        if (n == 40 && ph == 3) begin
          start <= 1'b0;
          while (wheel_q.size() != 0) @(posedge clk);
        end
      end
      start <= 1'b0;
      drain();
    end

    if (!failed) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/swk_pkg.sv
design/swk_vec.sv
design/swk_cordic.sv
design/swk_post.sv
design/swerve_wheel_kinematics.sv
tb/tb.sv
